// ----- rtl/cll_pkg.sv -----
`timescale 1ns / 1ps

package cll_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_TEND  = 3'd1,
    KIND_COMMA = 3'd2,
    KIND_EOL   = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_EOI   = 3'd5
  } kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_BARE    = 6'b000010,
    MODE_QUOTED  = 6'b000100,
    MODE_QESC    = 6'b001000,
    MODE_QCLOSED = 6'b010000,
    MODE_DISCARD = 6'b100000
  } mode_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_NL = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // one classified input: up to two results
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } entry_t;

endpackage

// ----- rtl/cll_front.sv -----
`timescale 1ns / 1ps

module cll_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  cll_pkg::in_item_t in_item_i,
  output logic              wr_en_o,
  output cll_pkg::entry_t   wr_entry_o,
  input  logic              q_full_i
);

  cll_pkg::mode_e mode_q, mode_d;
  logic           acc;
  logic [1:0]     cnt;
  cll_pkg::kind_e k0, k1;
  logic [7:0]     v0, v1;
  logic [7:0]     c;

  function automatic logic is_blank(input logic [7:0] x);
    return x == 8'h20 || x == 8'h09 || x == 8'h0B || x == 8'h0C || x == 8'h0D;
  endfunction

  function automatic logic is_word(input logic [7:0] x);
    return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A) ||
           (x >= 8'h30 && x <= 8'h39) || x == cll_pkg::CH_USCORE ||
           x == cll_pkg::CH_DASH;
  endfunction

  assign full = q_full_i;
  assign acc  = push && !q_full_i;
  assign c    = in_item_i.ch;

  always_comb begin
    mode_d = mode_q;
    cnt    = 2'd0;
    k0     = cll_pkg::KIND_CHAR;
    k1     = cll_pkg::KIND_CHAR;
    v0     = 8'd0;
    v1     = 8'd0;
    if (in_item_i.end_of_input) begin
      mode_d = cll_pkg::MODE_IDLE;
      if (mode_q == cll_pkg::MODE_BARE || mode_q == cll_pkg::MODE_QCLOSED) begin
        cnt = 2'd2; k0 = cll_pkg::KIND_TEND; k1 = cll_pkg::KIND_EOI;
      end else if (mode_q == cll_pkg::MODE_QUOTED || mode_q == cll_pkg::MODE_QESC) begin
        cnt = 2'd2; k0 = cll_pkg::KIND_ERR; k1 = cll_pkg::KIND_EOI;
      end else begin
        cnt = 2'd1; k0 = cll_pkg::KIND_EOI;
      end
    end else begin
      unique case (mode_q)
        cll_pkg::MODE_BARE, cll_pkg::MODE_QCLOSED: begin
          if (c == cll_pkg::CH_COMMA || c == cll_pkg::CH_NL) begin
            cnt = 2'd2; k0 = cll_pkg::KIND_TEND;
            k1 = (c == cll_pkg::CH_COMMA) ? cll_pkg::KIND_COMMA : cll_pkg::KIND_EOL;
            mode_d = cll_pkg::MODE_IDLE;
          end else if (is_blank(c)) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_TEND;
            mode_d = cll_pkg::MODE_IDLE;
          end else if (mode_q == cll_pkg::MODE_BARE && is_word(c)) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_CHAR; v0 = c;
          end else begin
            cnt = 2'd1; k0 = cll_pkg::KIND_ERR;
            mode_d = cll_pkg::MODE_DISCARD;
          end
        end
        cll_pkg::MODE_QUOTED: begin
          if (c == cll_pkg::CH_BSLASH) begin
            mode_d = cll_pkg::MODE_QESC;
          end else if (c == cll_pkg::CH_QUOTE) begin
            mode_d = cll_pkg::MODE_QCLOSED;
          end else if (c == cll_pkg::CH_NL) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_ERR;
            mode_d = cll_pkg::MODE_IDLE;
          end else begin
            cnt = 2'd1; k0 = cll_pkg::KIND_CHAR; v0 = c;
          end
        end
        cll_pkg::MODE_QESC: begin
          if (c == cll_pkg::CH_QUOTE) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_CHAR; v0 = c;
            mode_d = cll_pkg::MODE_QUOTED;
          end else if (c == cll_pkg::CH_NL) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_ERR;
            mode_d = cll_pkg::MODE_IDLE;
          end else if (c == cll_pkg::CH_BSLASH) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_CHAR; v0 = cll_pkg::CH_BSLASH;
            mode_d = cll_pkg::MODE_QESC;
          end else begin
            // escaped non-quote: literal backslash, then the byte itself
            cnt = 2'd2; k0 = cll_pkg::KIND_CHAR; v0 = cll_pkg::CH_BSLASH;
            k1 = cll_pkg::KIND_CHAR; v1 = c;
            mode_d = cll_pkg::MODE_QUOTED;
          end
        end
        cll_pkg::MODE_DISCARD: begin
          if (c == cll_pkg::CH_NL) mode_d = cll_pkg::MODE_IDLE;
        end
        default: begin
          mode_d = cll_pkg::MODE_IDLE;
          if (c == cll_pkg::CH_NL) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_EOL;
          end else if (is_blank(c)) begin
            cnt = 2'd0;
          end else if (c == cll_pkg::CH_QUOTE) begin
            mode_d = cll_pkg::MODE_QUOTED;
          end else if (c == cll_pkg::CH_COMMA) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_COMMA;
          end else if (is_word(c)) begin
            cnt = 2'd1; k0 = cll_pkg::KIND_CHAR; v0 = c;
            mode_d = cll_pkg::MODE_BARE;
          end else begin
            cnt = 2'd1; k0 = cll_pkg::KIND_ERR;
            mode_d = cll_pkg::MODE_DISCARD;
          end
        end
      endcase
    end
  end

  assign wr_en_o          = acc && (cnt != 2'd0);
  assign wr_entry_o.two   = cnt[1];
  assign wr_entry_o.r0    = '{kind: k0, value: v0, last: !cnt[1]};
  assign wr_entry_o.r1    = '{kind: k1, value: v1, last: 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cll_pkg::MODE_IDLE;
    end else if (acc) begin
      mode_q <= mode_d;
    end
  end

endmodule

// ----- rtl/cll_fifo.sv -----
`timescale 1ns / 1ps

module cll_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  cll_pkg::entry_t wr_entry_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output cll_pkg::entry_t rd_entry_o,
  output logic            empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  cll_pkg::entry_t mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o     = cnt_q == FullCnt;
  assign empty_o    = cnt_q == '0;
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && !empty_o;
  assign rd_entry_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == LastPtr) ? '0 : wp_q + AW'(1);
      if (do_rd) rp_q <= (rp_q == LastPtr) ? '0 : rp_q + AW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// ----- rtl/cll_back.sv -----
`timescale 1ns / 1ps

module cll_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cll_pkg::entry_t    rd_entry_i,
  input  logic               q_empty_i,
  output logic               rd_en_o,
  output logic               empty,
  input  logic               pop,
  output cll_pkg::out_item_t out_item_o
);

  logic               valid_q;
  logic               sel_q, sel_d;
  cll_pkg::out_item_t data_q;
  logic               load;

  assign load    = !q_empty_i && (!valid_q || pop);
  assign rd_en_o = load && (!rd_entry_i.two || sel_q);
  assign sel_d   = load ? (rd_entry_i.two && !sel_q) : sel_q;

  assign empty      = !valid_q;
  assign out_item_o = data_q;

  always_ff @(posedge clk_i) begin
    if (load) data_q <= sel_q ? rd_entry_i.r1 : rd_entry_i.r0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) valid_q <= 1'b1;
      else if (pop) valid_q <= 1'b0;
    end
  end

endmodule

// ----- rtl/command_line_lexer.sv -----
`timescale 1ns / 1ps

// Streaming command line lexer, one character per item.
// Input channel: in_item_i carries ch and end_of_input; an item is taken
// on a clock edge with push high and full low.
// Result channel: out_item_o carries kind, value and last; it is valid while
// empty is low and is taken on an edge with pop high.
// Each item yields zero, one or two results; last marks the final one.
// The front end classifies an item in its accept cycle and writes its
// results as one entry into a QueueDepth-entry queue; the back end moves
// them into the output register, one per cycle while it is empty or popped.
// Each result passes through the queue and then the output register.
// Throughput: one item per cycle on the input while full is low, one result
// per cycle on the output while pop is high; two results leave in turn.
// When pop stays low the queue fills and full rises; nothing is lost.
// Reset puts the lexer in idle mode and empties queue and output register.

module command_line_lexer #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cll_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output cll_pkg::out_item_t out_item_o
);

  logic            wr_en, rd_en, q_full, q_empty;
  cll_pkg::entry_t wr_entry, rd_entry;

  cll_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry),
    .q_full_i   (q_full)
  );

  cll_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .full_o     (q_full),
    .rd_en_i    (rd_en),
    .rd_entry_o (rd_entry),
    .empty_o    (q_empty)
  );

  cll_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_entry_i (rd_entry),
    .q_empty_i  (q_empty),
    .rd_en_o    (rd_en),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cll_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_item_t in_item = '0;
  out_item_t out_item;

  mode_e lex_state = MODE_IDLE;
  out_item_t step_results[$];
  out_item_t expected_events[$];

  int err_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int hold_request = 0;
  bit bursty = 1'b1;
  int burst_left = 4;

  command_line_lexer dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // lexer prediction
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_USCORE || c == CH_DASH;
  endfunction

  function automatic void add_result(kind_e k, logic [7:0] v);
    out_item_t r;
    r.kind = k;
    r.value = v;
    r.last = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void quoted_char(logic [7:0] c);
    if (c == CH_BSLASH) begin
      lex_state = MODE_QESC;
    end else if (c == CH_QUOTE) begin
      lex_state = MODE_QCLOSED;
    end else if (c == CH_NL) begin
      add_result(KIND_ERR, 8'h00);
      lex_state = MODE_IDLE;
    end else begin
      add_result(KIND_CHAR, c);
    end
  endfunction

  function automatic int lex_predict(in_item_t it);
    logic [7:0] c;
    c = it.ch;
    step_results.delete();
    if (it.end_of_input) begin
      if (lex_state == MODE_BARE || lex_state == MODE_QCLOSED) begin
        add_result(KIND_TEND, 8'h00);
      end else if (lex_state == MODE_QUOTED || lex_state == MODE_QESC) begin
        add_result(KIND_ERR, 8'h00);
      end
      add_result(KIND_EOI, 8'h00);
      lex_state = MODE_IDLE;
    end else begin
      case (lex_state)
        MODE_BARE, MODE_QCLOSED: begin
          if (c == CH_COMMA || c == CH_NL) begin
            add_result(KIND_TEND, 8'h00);
            add_result(c == CH_COMMA ? KIND_COMMA : KIND_EOL, 8'h00);
            lex_state = MODE_IDLE;
          end else if (is_blank(c)) begin
            add_result(KIND_TEND, 8'h00);
            lex_state = MODE_IDLE;
          end else if (lex_state == MODE_BARE && is_word(c)) begin
            add_result(KIND_CHAR, c);
          end else begin
            add_result(KIND_ERR, 8'h00);
            lex_state = MODE_DISCARD;
          end
        end
        MODE_QUOTED: quoted_char(c);
        MODE_QESC: begin
          if (c == CH_QUOTE) begin
            add_result(KIND_CHAR, c);
            lex_state = MODE_QUOTED;
          end else if (c == CH_NL) begin
            add_result(KIND_ERR, 8'h00);
            lex_state = MODE_IDLE;
          end else begin
            // backslash was literal after all
            add_result(KIND_CHAR, CH_BSLASH);
            lex_state = MODE_QUOTED;
            quoted_char(c);
          end
        end
        MODE_DISCARD: begin
          if (c == CH_NL) lex_state = MODE_IDLE;
        end
        default: begin
          lex_state = MODE_IDLE;
          if (c == CH_NL) begin
            add_result(KIND_EOL, 8'h00);
          end else if (is_blank(c)) begin
          end else if (c == CH_QUOTE) begin
            lex_state = MODE_QUOTED;
          end else if (c == CH_COMMA) begin
            add_result(KIND_COMMA, 8'h00);
          end else if (is_word(c)) begin
            add_result(KIND_CHAR, c);
            lex_state = MODE_BARE;
          end else begin
            add_result(KIND_ERR, 8'h00);
            lex_state = MODE_DISCARD;
          end
        end
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_events.insert(expected_events.size(), step_results[i]);
    return step_results.size();
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result with nothing pending, kind", int'(out_item.kind), -1);
      end else begin
        want = expected_events.pop_front();
        if (out_item.kind !== want.kind)
          report_mismatch("kind", int'(out_item.kind), int'(want.kind));
        if (out_item.value !== want.value)
          report_mismatch("value", int'(out_item.value), int'(want.value));
        if (out_item.last !== want.last)
          report_mismatch("last", int'(out_item.last), int'(want.last));
      end
    end
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int pattern_age;
    logic [15:0] stall_pattern;
    hold_left = 0;
    pattern_age = 0;
    stall_pattern = 16'hFFFF;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      pattern_age++;
      if (pattern_age >= 64) begin
        pattern_age = $urandom_range(0, 31);
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'h00FF;
          default: stall_pattern = 16'h1111 << $urandom_range(0, 3);
        endcase
        if (stall_pattern == 16'h0000) stall_pattern = 16'h8001;
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic eoi);
    in_item_t it;
    int gap;
    it.ch = c;
    it.end_of_input = eoi;
    @(negedge clk);
    push <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
    end while (full);
    void'(lex_predict(it));
    items_sent++;
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 7);
        it.ch = 8'($urandom);
        it.end_of_input = 1'($urandom);
        @(negedge clk);
        push <= 1'b0;
        in_item <= it;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 4))
      0: return 8'(8'h61 + $urandom_range(0, 25));
      1: return 8'(8'h41 + $urandom_range(0, 25));
      2: return 8'(8'h30 + $urandom_range(0, 9));
      3: return CH_USCORE;
      default: return CH_DASH;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] plain_quoted_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_QUOTE || c == CH_BSLASH || c == CH_NL);
    return c;
  endfunction

  task automatic send_delimiter();
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1)) send_item(blank_char(), 1'b0);
      send_item(CH_COMMA, 1'b0);
      if ($urandom_range(0, 1)) send_item(blank_char(), 1'b0);
    end else begin
      repeat ($urandom_range(1, 2)) send_item(blank_char(), 1'b0);
    end
  endtask

  // one command line; a broken line tampers with one token
  task automatic send_line(input bit broken);
    int ntok;
    int fault;
    int len;
    int bad_pos;
    logic [7:0] c;
    ntok = $urandom_range(1, 5);
    fault = broken ? $urandom_range(0, ntok - 1) : -1;
    for (int k = 0; k < ntok; k++) begin
      if (k > 0) send_delimiter();
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(0, 6);
        send_item(CH_QUOTE, 1'b0);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 2))
              0: c = CH_QUOTE;
              1: c = CH_BSLASH;
              default: c = plain_quoted_char();
            endcase
            send_item(c, 1'b0);
          end else begin
            send_item(plain_quoted_char(), 1'b0);
          end
        end
        if (k == fault && $urandom_range(0, 1)) begin
          // line ends inside the quote
          send_item(CH_NL, $urandom_range(0, 3) == 0);
          return;
        end
        send_item(CH_QUOTE, 1'b0);
        if (k == fault) send_item(8'($urandom), 1'b0);
      end else begin
        len = $urandom_range(1, 6);
        bad_pos = (k == fault) ? $urandom_range(0, len - 1) : -1;
        for (int j = 0; j < len; j++) begin
          send_item(j == bad_pos ? 8'($urandom) : word_char(), 1'b0);
        end
      end
    end
    if ($urandom_range(0, 3) == 0) send_item(blank_char(), 1'b0);
    if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b1);
    else send_item(CH_NL, 1'b0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_item(8'($urandom), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_end_of_input();
    send_item(8'hFF, 1'b1);
    send_text("a");
    send_item(8'h00, 1'b1);
    send_text("\"");
    send_item(8'hAA, 1'b1);
  endtask

  task automatic test_bare_tokens();
    send_text("Z\t9_,\n");
  endtask

  task automatic test_quoted_tokens();
    // escaped quote, then a doubled backslash before a plain byte
    send_text("\"\\\"\\\\");
    send_item(8'hFF, 1'b0);
    send_text("\"\n");
    // pending backslash dropped when the line fails
    send_text("\"\\\n");
  endtask

  task automatic test_error_recovery();
    send_text("b");
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_text("\"\"z\n");
  endtask

  task automatic test_backpressure();
    bursty = 1'b0;
    hold_request = 150;
    repeat (4) send_line(1'b0);
    bursty = 1'b1;
  endtask

  task automatic test_random_lines();
    int r;
    while (items_sent < RANDOM_ITEMS) begin
      bursty = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) send_noise();
      else send_line(r == 1);
    end
    bursty = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_end_of_input();
    test_bare_tokens();
    test_quoted_tokens();
    test_error_recovery();
    test_backpressure();
    test_random_lines();
    @(negedge clk);
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!empty) report_mismatch("result left over, kind", int'(out_item.kind), -1);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
